/* design/cfa_pkg.sv */
// cfa_pkg: shared constants and types for the continued fraction approximator.
// No dependencies; imported by cfa_div, continued_fraction_approximator, cfa_checker and tb.
package cfa_pkg;

    // Fixed-point format of the input value
    localparam int FRAC_BITS = 32;
    localparam int VALUE_W   = 64;
    localparam int CONV_W    = 32;
    localparam int TERMS_W   = 6;

    // Divider step counter width (one quotient bit per cycle)
    localparam int DIV_CNT_W = $clog2(VALUE_W);

    // Fixed-point one, i.e. 2^FRAC_BITS
    localparam logic [VALUE_W-1:0] FIX_ONE = VALUE_W'(1) << FRAC_BITS;

    localparam logic [TERMS_W-1:0] MAX_TERMS_RST = TERMS_W'(16);

    // Divider status back to the sequencer
    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [VALUE_W-1:0]   remainder;
    } div_status_t;

endpackage

/* design/cfa_div.sv */
// cfa_div: restoring bit-serial 64-bit unsigned divider, one quotient bit per cycle.
// Depends on cfa_pkg.
module cfa_div
    import cfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] dividend,
    input  logic [VALUE_W-1:0] divisor,
    output div_status_t        status
);

    logic [VALUE_W-1:0]   quo_reg, quo_next;
    logic [VALUE_W-1:0]   rem_reg, rem_next;
    logic [VALUE_W-1:0]   dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [VALUE_W:0]     shifted;
    logic [VALUE_W:0]     diff;
    logic                 fits;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        shifted = {rem_reg, quo_reg[VALUE_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_W-2:0], fits};
            rem_next = fits ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.done      = done_reg;
    assign status.quotient  = quo_reg;
    assign status.remainder = rem_reg;

endmodule

/* design/continued_fraction_approximator.sv */
// Continued fraction approximator: Euclid expansion of a Q32.32 value, one term at a time.
// The first term is the integer part, split off with the fraction bits when the value is
// accepted; each later term runs through the serial divider, then the shared multiplier
// (S_MULN, S_ADDN, S_ADDD). One value is worked at a time: in_stall stays high until the
// result is in the output reg, so the next item is accepted only after that.
// Reset (rst_n, async, active low) clears control, max_terms 16. Depends on cfa_pkg, cfa_div.
module continued_fraction_approximator
    import cfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [TERMS_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CONV_W-1:0]  numerator,
    output logic [CONV_W-1:0]  denominator,
    output logic [TERMS_W-1:0] terms_used,
    output logic               exact
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MULN = 3'd2;
    localparam logic [2:0] S_ADDN = 3'd3;
    localparam logic [2:0] S_ADDD = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [TERMS_W-1:0] max_terms_reg;
    logic [VALUE_W-1:0] q_reg, q_next;
    logic [VALUE_W-1:0] rem_reg, rem_next;
    logic [CONV_W-1:0]  a_reg, a_next;
    logic [CONV_W-1:0]  prod_reg, prod_next;
    logic [CONV_W-1:0]  num1_reg, num1_next, num2_reg, num2_next;
    logic [CONV_W-1:0]  den1_reg, den1_next, den2_reg, den2_next;
    logic [TERMS_W-1:0] used_reg, used_next;
    logic               exact_reg, exact_next;

    logic               out_valid_reg, out_valid_next;
    logic [CONV_W-1:0]  out_num_reg, out_num_next;
    logic [CONV_W-1:0]  out_den_reg, out_den_next;
    logic [TERMS_W-1:0] out_used_reg, out_used_next;
    logic               out_exact_reg, out_exact_next;

    logic               in_accept;
    logic               out_free;
    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    logic [VALUE_W-1:0] div_divisor;
    logic [CONV_W-1:0]  mul_b;
    logic [2*CONV_W-1:0] mul_full;
    div_status_t        div_st;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Shared divider: old divisor over the last remainder
    assign div_dividend = q_reg;
    assign div_divisor  = rem_reg;

    cfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_st)
    );

    // Shared multiplier: term times num1, then term times den1
    assign mul_b    = (state_reg == S_MULN) ? num1_reg : den1_reg;
    assign mul_full = a_reg * mul_b;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        a_next     = a_reg;
        prod_next  = prod_reg;
        num1_next  = num1_reg;
        num2_next  = num2_reg;
        den1_next  = den1_reg;
        den2_next  = den2_reg;
        used_next  = used_reg;
        exact_next = exact_reg;
        div_start  = 1'b0;

        out_valid_next = out_valid_reg && out_stall;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_used_next  = out_used_reg;
        out_exact_next = out_exact_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    // First term: integer part is the quotient by 2^FRAC_BITS,
                    // the fraction bits are the remainder
                    q_next     = FIX_ONE;
                    a_next     = CONV_W'(value >> FRAC_BITS);
                    rem_next   = value & (FIX_ONE - VALUE_W'(1));
                    num1_next  = CONV_W'(1);
                    num2_next  = '0;
                    den1_next  = '0;
                    den2_next  = CONV_W'(1);
                    used_next  = '0;
                    exact_next = 1'b0;
                    if (max_terms_reg == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MULN;
                    end
                end
            end
            S_DIV:
            begin
                if (div_st.done)
                begin
                    a_next     = div_st.quotient[CONV_W-1:0];
                    rem_next   = div_st.remainder;
                    state_next = S_MULN;
                end
            end
            S_MULN:
            begin
                prod_next  = mul_full[CONV_W-1:0];
                state_next = S_ADDN;
            end
            S_ADDN:
            begin
                num1_next  = num2_reg + prod_reg;
                num2_next  = num1_reg;
                prod_next  = mul_full[CONV_W-1:0];
                state_next = S_ADDD;
            end
            S_ADDD:
            begin
                den1_next = den2_reg + prod_reg;
                den2_next = den1_reg;
                used_next = used_reg + 1'b1;
                if (rem_reg == '0)
                begin
                    exact_next = 1'b1;
                    state_next = S_FIN;
                end
                else if (used_next == max_terms_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    // Euclid shift: divide old divisor by the remainder
                    div_start  = 1'b1;
                    q_next     = rem_reg;
                    state_next = S_DIV;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = (used_reg == '0) ? '0 : num1_reg;
                    out_den_next   = (used_reg == '0) ? '0 : den1_reg;
                    out_used_next  = used_reg;
                    out_exact_next = exact_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            max_terms_reg <= MAX_TERMS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                max_terms_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        q_reg         <= q_next;
        rem_reg       <= rem_next;
        a_reg         <= a_next;
        prod_reg      <= prod_next;
        num1_reg      <= num1_next;
        num2_reg      <= num2_next;
        den1_reg      <= den1_next;
        den2_reg      <= den2_next;
        used_reg      <= used_next;
        exact_reg     <= exact_next;
        out_num_reg   <= out_num_next;
        out_den_reg   <= out_den_next;
        out_used_reg  <= out_used_next;
        out_exact_reg <= out_exact_next;
    end

    assign out_valid   = out_valid_reg;
    assign numerator   = out_num_reg;
    assign denominator = out_den_reg;
    assign terms_used  = out_used_reg;
    assign exact       = out_exact_reg;

endmodule

/* test/cfa_checker.sv */
// cfa_checker: watches the config, input and result channels of the continued fraction
// approximator, predicts each result and compares it field by field.
// Depends on cfa_pkg for widths and the reset term limit.
module cfa_checker
    import cfa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [TERMS_W-1:0] cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [VALUE_W-1:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [CONV_W-1:0]  numerator,
    input  logic [CONV_W-1:0]  denominator,
    input  logic [TERMS_W-1:0] terms_used,
    input  logic               exact,
    output int                 mismatch_count,
    output int                 fracs_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CONV_W-1:0]  numer;
        logic [CONV_W-1:0]  denom;
        logic [TERMS_W-1:0] terms;
        logic               whole;
    } fraction_t;

    logic [TERMS_W-1:0] term_limit;
    fraction_t          expected_fracs[$];

    // Euclid on (value, 2^FRAC_BITS) with wrapped convergent recurrences
    function automatic fraction_t expand_value(logic [VALUE_W-1:0] v,
                                               logic [TERMS_W-1:0] lim);
        logic [VALUE_W-1:0] p;
        logic [VALUE_W-1:0] q;
        logic [VALUE_W-1:0] quo;
        logic [VALUE_W-1:0] rem;
        logic [CONV_W-1:0]  a;
        logic [CONV_W-1:0]  n1;
        logic [CONV_W-1:0]  n2;
        logic [CONV_W-1:0]  d1;
        logic [CONV_W-1:0]  d2;
        fraction_t          r;
        int                 k;
        p  = v;
        q  = FIX_ONE;
        n1 = 1;
        n2 = 0;
        d1 = 0;
        d2 = 1;
        r  = '0;
        for (k = 0; k < int'(lim) && !r.whole; k++)
        begin
            quo = p / q;
            rem = p % q;
            a   = quo[CONV_W-1:0];
            r.numer = n2 + a * n1;
            r.denom = d2 + a * d1;
            n2 = n1;
            n1 = r.numer;
            d2 = d1;
            d1 = r.denom;
            r.terms = r.terms + 1'b1;
            // remainder zero: this term closes the expansion
            if (rem == 0)
                r.whole = 1'b1;
            else
            begin
                p = q;
                q = rem;
            end
        end
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Track the term limit, queue predictions, score results
    always @(posedge clk or negedge rst_n)
    begin
        fraction_t want;
        if (!rst_n)
        begin
            term_limit = MAX_TERMS_RST;
            expected_fracs.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_fracs.push_back(expand_value(value, term_limit));
            if (cfg_wr_en)
                term_limit = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (expected_fracs.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0h/%0h terms %0d exact %b",
                             $time, numerator, denominator, terms_used, exact);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_fracs.pop_front();
                    compare_field("numerator", 64'(want.numer), 64'(numerator));
                    compare_field("denominator", 64'(want.denom), 64'(denominator));
                    compare_field("terms_used", 64'(want.terms), 64'(terms_used));
                    compare_field("exact", 64'(want.whole), 64'(exact));
                end
            end
        end
        fracs_pending = expected_fracs.size();
    end

endmodule

/* test/tb.sv */
// tb: stimulus and verdict for continued_fraction_approximator; cfa_checker does the scoring.
// Depends on cfa_pkg, continued_fraction_approximator and cfa_checker.
module tb;
    import cfa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Final settle time, sized for the worst item of 63 terms
    localparam int ITEM_CYCLES = 70 * 64;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [TERMS_W-1:0] cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [VALUE_W-1:0] value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CONV_W-1:0]  numerator;
    logic [CONV_W-1:0]  denominator;
    logic [TERMS_W-1:0] terms_used;
    logic               exact;
    int                 mismatch_count;
    int                 fracs_pending;
    bit                 no_idle = 1'b0;

    always #6 clk = ~clk;

    continued_fraction_approximator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .numerator   (numerator),
        .denominator (denominator),
        .terms_used  (terms_used),
        .exact       (exact)
    );

    cfa_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .numerator      (numerator),
        .denominator    (denominator),
        .terms_used     (terms_used),
        .exact          (exact),
        .mismatch_count (mismatch_count),
        .fracs_pending  (fracs_pending)
    );

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 200);
    endfunction

    // Random fixed-point values of several shapes
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: ;
            1: v = v >> $urandom_range(1, 63);
            // low bits clear: expansion ends early and exact
            2: v = v << $urandom_range(1, 40);
            3: v[63:32] = 32'($urandom_range(0, 4));
            // close to an integer
            4: v = {32'($urandom_range(0, 7)), 32'($urandom_range(0, 3))} - 64'($urandom_range(0, 1));
            // small rational n/d
            default: v = (64'($urandom_range(1, 1000)) << FRAC_BITS) / 64'($urandom_range(1, 1000));
        endcase
        return v;
    endfunction

    // Present one item, hold until accepted, then maybe idle
    task automatic send_value(logic [VALUE_W-1:0] v);
        int gap;
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (in_stall);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            value    <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until every predicted result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (fracs_pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_term_limit(logic [TERMS_W-1:0] lim);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side back-pressure
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 8)) @(posedge clk);
        end
    end

    // Watchdog
    initial
    begin
        #(80_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int ph;
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset limit of 16: extremes, one, zero, long expansions
        send_value(64'h0);
        send_value(64'h1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'h0000_0001_0000_0000);
        send_value(64'h0000_0000_8000_0000);
        send_value(64'hFFFF_FFFF_0000_0000);
        send_value(64'h0000_0000_FFFF_FFFF);
        send_value(64'h0000_0001_9E37_79B9);
        send_value(64'h0000_0003_243F_6A88);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        send_value(64'h0000_0000_0000_0003);

        // Zero term limit gives 0/0
        wait_drained();
        write_term_limit(6'd0);
        send_value(64'h0000_0002_4000_0000);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);

        // Full limit: long expansions and wrapped convergents
        wait_drained();
        write_term_limit(6'd63);
        send_value(64'h0000_0001_9E37_79B9);
        send_value(64'h0000_0003_243F_6A88);
        send_value(64'h1);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'hFFFF_FFFF_0000_0001);
        send_value(64'h0);

        // Single term: integer part only
        wait_drained();
        write_term_limit(6'd1);
        send_value(64'h0000_0007_8000_0000);
        send_value(64'h0000_0000_0000_0001);

        // Random phases, even ones at the full limit
        for (ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            no_idle = (ph == 2 || ph == 5);
            write_term_limit((ph % 2 == 0) ? 6'd63 : 6'($urandom_range(0, 63)));
            for (n = 0; n < 32; n++)
                send_value(rand_value());
        end

        wait_drained();
        repeat (ITEM_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && fracs_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
design/cfa_pkg.sv
design/cfa_div.sv
design/continued_fraction_approximator.sv
test/cfa_checker.sv
test/tb.sv
